// ----- rtl/sha1_pkg.sv -----
// Shared constants and types for the SHA-1 message digest block.
package sha1_pkg;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam int QueueDepth = 2;
  localparam int QueueAw    = 1;

  // Queue entry between front and back ends.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       final_item;
  } sha1_item_t;

endpackage

// ----- rtl/sha1_message_digest_top.sv -----
// Top level of the streaming SHA-1 message digest block.
// Operation: a byte item is absorbed into the block buffer; a byte closing a 64-byte
// block then runs 80 rounds, one per cycle, and folds the result into the chain.
// A final item pads one byte per cycle, with 80 rounds and a fold per padded block,
// then emits five digest words, one per cycle with out_tready high.
// Throughput: one item at a time in the back end; a 2-entry queue decouples input.
// Reset: synchronous active-low rst_n restores the initial hash and clears counts.
module sha1_message_digest_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // final_item
  input  logic        in_tuser,   // has_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, zero fill
  output logic        out_tlast   // last_word
);
  import sha1_pkg::*;

  sha1_item_t in_item, q_item;
  logic       q_valid, q_ready;
  logic [31:0] word;
  logic [2:0]  idx;

  assign in_item.data_byte  = in_tdata;
  assign in_item.has_byte   = in_tuser;
  assign in_item.final_item = in_tlast;

  // Hold items in the queue while the compression loop runs.
  sha1_front u_front (
    .clk, .rst_n,
    .in_valid (in_tvalid), .in_ready (in_tready), .in_item (in_item),
    .q_valid, .q_ready, .q_item
  );

  sha1_core u_core (
    .clk, .rst_n,
    .q_valid, .q_ready, .q_item,
    .out_tvalid, .out_tready,
    .out_word (word), .out_index (idx), .out_last (out_tlast)
  );

  assign out_tdata = {5'd0, idx, word};
endmodule

// ----- rtl/sha1_front.sv -----
// Input front end: accept items, drop empty non-final items, queue the rest.
module sha1_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sha1_pkg::sha1_item_t in_item,
  output logic               q_valid,
  input  logic               q_ready,
  output sha1_pkg::sha1_item_t q_item
);
  import sha1_pkg::*;

  sha1_item_t             mem_r [QueueDepth];
  logic [QueueAw-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QueueAw:0]       cnt_r, cnt_nxt;
  logic                   push, pop;

  assign in_ready = (cnt_r != QueueAw'(0) + (QueueAw+1)'(QueueDepth));
  assign push     = in_valid && in_ready && (in_item.has_byte || in_item.final_item);
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_valid && q_ready;
  assign q_item   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_item;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QueueAw+1)'(QueueDepth)) else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0) else $error("pop from empty queue");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count slip");
`endif
endmodule

// ----- rtl/sha1_core.sv -----
// Back end: block packing, padding, 80-round compression and digest output.
module sha1_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  sha1_pkg::sha1_item_t q_item,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_word,
  output logic [2:0]           out_index,
  output logic                 out_last
);
  import sha1_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_RND  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  st_r, st_nxt;
  logic [31:0] h_r [5];
  logic [31:0] w_r [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [63:0] bits_r;
  logic [5:0]  pos_r;
  logic [6:0]  rnd_r;
  logic        fin_r;     // padding in progress
  logic        lenph_r;   // past the 0x80 byte
  logic        lenblk_r;  // current block carries the bit length
  logic        done_r;    // last padded block filled and sent to the rounds
  logic [2:0]  oidx_r;

  logic [7:0]  pbyte;
  logic        pwrite;
  logic [31:0] f, kc, wt, tmp, wnew;
  logic [5:0]  lenbyte;

  assign q_ready = (st_r == S_IDLE);

  // Padding byte for the current position.
  always_comb begin
    lenbyte = pos_r - 6'd56;
    if (!lenph_r) pbyte = 8'h80;
    else if (lenblk_r && pos_r >= 6'd56) pbyte = bits_r[8*(7-lenbyte[2:0]) +: 8];
    else pbyte = 8'h00;
  end

  always_comb begin
    if (rnd_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r); kc = K0;
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r; kc = K1;
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r); kc = K2;
    end else begin
      f = b_r ^ c_r ^ d_r; kc = K3;
    end
    wnew = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    wnew = {wnew[30:0], wnew[31]};
    wt   = (rnd_r < 7'd16) ? w_r[0] : wnew;
    tmp  = {a_r[26:0], a_r[31:27]} + f + e_r + wt + kc;
  end

  assign pwrite = (st_r == S_IDLE && q_valid && q_item.has_byte) || (st_r == S_PAD);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (q_valid) begin
        if (q_item.has_byte && pos_r == 6'd63) st_nxt = S_RND;
        else if (q_item.final_item) st_nxt = S_PAD;
      end
      S_PAD:  if (pos_r == 6'd63) st_nxt = S_RND;
      S_RND:  if (rnd_r == 7'd79) st_nxt = S_ADD;
      S_ADD:  st_nxt = !fin_r ? S_IDLE : (done_r ? S_OUT : S_PAD);
      S_OUT:  if (out_tready && oidx_r == 3'd4) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      pos_r    <= '0;
      bits_r   <= '0;
      rnd_r    <= '0;
      fin_r    <= 1'b0;
      lenph_r  <= 1'b0;
      lenblk_r <= 1'b0;
      done_r   <= 1'b0;
      oidx_r   <= '0;
      a_r <= '0; b_r <= '0; c_r <= '0; d_r <= '0; e_r <= '0;
      h_r[0] <= H0; h_r[1] <= H1; h_r[2] <= H2; h_r[3] <= H3; h_r[4] <= H4;
    end else begin
      case (st_r)
        S_IDLE: if (q_valid) begin
          if (q_item.has_byte) begin
            pos_r  <= pos_r + 6'd1;
            bits_r <= bits_r + 64'd8;
          end
          fin_r   <= q_item.final_item;
          lenph_r <= 1'b0;
          done_r  <= 1'b0;
          rnd_r   <= '0;
          if (q_item.has_byte && pos_r == 6'd63) begin
            a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
          end
          st_r <= st_nxt;
        end
        S_PAD: begin
          pos_r   <= pos_r + 6'd1;
          lenph_r <= 1'b1;
          rnd_r   <= '0;
          // The length goes in this block only if the 0x80 byte left room for it.
          lenblk_r <= (pos_r == 6'd63) ? 1'b1 :
                      (!lenph_r ? (pos_r < 6'd56) : lenblk_r);
          if (lenph_r && lenblk_r && pos_r == 6'd63) done_r <= 1'b1;
          if (pos_r == 6'd63) begin
            a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
            st_r <= S_RND;
          end
        end
        S_RND: begin
          e_r <= d_r; d_r <= c_r; c_r <= {b_r[1:0], b_r[31:2]}; b_r <= a_r; a_r <= tmp;
          rnd_r <= rnd_r + 7'd1;
          if (rnd_r == 7'd79) st_r <= S_ADD;
        end
        S_ADD: begin
          h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r; h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r; h_r[4] <= h_r[4] + e_r;
          oidx_r <= '0;
          st_r   <= st_nxt;
        end
        S_OUT: if (out_tready) begin
          oidx_r <= oidx_r + 3'd1;
          if (oidx_r == 3'd4) begin
            st_r   <= S_IDLE;
            pos_r  <= '0;
            bits_r <= '0;
            fin_r  <= 1'b0;
            h_r[0] <= H0; h_r[1] <= H1; h_r[2] <= H2; h_r[3] <= H3; h_r[4] <= H4;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // Byte packing into the block buffer, and the message schedule shift.
  always_ff @(posedge clk) begin
    if (st_r == S_RND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wt;
    end else if (pwrite) begin
      w_r[pos_r[5:2]][8*(3-pos_r[1:0]) +: 8] <= (st_r == S_PAD) ? pbyte : q_item.data_byte;
    end
  end

  assign out_tvalid = (st_r == S_OUT);
  assign out_word   = h_r[oidx_r];
  assign out_index  = oidx_r;
  assign out_last   = (oidx_r == 3'd4);

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> oidx_r <= 3'd4) else $error("digest index out of range");
  a_round_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_RND |-> rnd_r < 7'd80) else $error("round counter overrun");
  a_out_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> fin_r && done_r) else $error("digest without padding");
`endif
endmodule

// ----- verif/tb_sha1_message_digest_top.sv -----
// Testbench for the streaming SHA-1 message digest block with an in-line digest predictor.
`timescale 1ns / 100ps

module tb_sha1_message_digest_top;
  import sha1_pkg::*;

  // Digest word as it leaves the block.
  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  // Predicts digests from accepted items and checks each word the block returns.
  class digest_scoreboard;
    logic [31:0]  chain[5];
    logic [31:0]  blk[16];
    logic [63:0]  bit_count;
    logic [5:0]   byte_pos;
    digest_word_t pending_words[$];
    int           errors;

    function new();
      errors = 0;
      rearm();
    endfunction

    function void rearm();
      chain[0] = H0; chain[1] = H1; chain[2] = H2; chain[3] = H3; chain[4] = H4;
      bit_count = '0;
      byte_pos  = '0;
    endfunction

    function void compress();
      logic [31:0] w[80];
      logic [31:0] a, b, c, d, e, f, k, tmp;
      for (int t = 0; t < 16; t++) w[t] = blk[t];
      for (int t = 16; t < 80; t++) begin
        tmp = w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16];
        w[t] = {tmp[30:0], tmp[31]};
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (int t = 0; t < 80; t++) begin
        if (t < 20) begin
          f = (b & c) | (~b & d); k = K0;
        end else if (t < 40) begin
          f = b ^ c ^ d; k = K1;
        end else if (t < 60) begin
          f = (b & c) | (b & d) | (c & d); k = K2;
        end else begin
          f = b ^ c ^ d; k = K3;
        end
        tmp = {a[26:0], a[31:27]} + f + e + w[t] + k;
        e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = tmp;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endfunction

    function void absorb(logic [7:0] value);
      blk[byte_pos[5:2]][(3 - byte_pos[1:0]) * 8 +: 8] = value;
      byte_pos++;
      if (byte_pos == 0) compress();
    endfunction

    // Take one accepted item; a final item queues the five digest words.
    function void note_item(logic [7:0] data_byte, logic has_byte, logic final_item);
      digest_word_t dw;
      if (has_byte) begin
        absorb(data_byte);
        bit_count += 64'd8;
      end
      if (!final_item) return;
      absorb(8'h80);
      while (byte_pos != 6'd56) absorb(8'h00);
      for (int i = 7; i >= 0; i--) absorb(bit_count[i*8 +: 8]);
      for (int i = 0; i < 5; i++) begin
        dw.word = chain[i]; dw.index = 3'(i); dw.last = (i == 4);
        pending_words.insert(pending_words.size(), dw);
      end
      rearm();
    endfunction

    function void check_word(logic [39:0] tdata, logic tlast);
      digest_word_t exp_w;
      if (pending_words.size() == 0) begin
        $error("unexpected digest word %h", tdata);
        errors++;
        return;
      end
      exp_w = pending_words.pop_front();
      if (tdata[31:0] !== exp_w.word) begin
        $error("digest_word expected %h actual %h", exp_w.word, tdata[31:0]);
        errors++;
      end
      if (tdata[34:32] !== exp_w.index) begin
        $error("word_index expected %0d actual %0d", exp_w.index, tdata[34:32]);
        errors++;
      end
      if (tlast !== exp_w.last) begin
        $error("last_word expected %b actual %b", exp_w.last, tlast);
        errors++;
      end
      if (tdata[39:35] !== 5'd0) begin
        $error("zero fill expected 0 actual %h", tdata[39:35]);
        errors++;
      end
    endfunction
  endclass

  localparam int WatchdogLimit = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tlast;   // final_item
  logic        in_tuser;   // has_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [31:0] digest_word, [34:32] word_index, zero fill
  logic        out_tlast;  // last_word

  digest_scoreboard sb;
  int  idle_cycles;
  int  items_sent;
  bit  hold_sink;

  sha1_message_digest_top u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap length: mostly short, now and then long.
  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(20, 90);
    return $urandom_range(0, 3);
  endfunction

  // Offer one item and hold it until the block takes it.
  task automatic send_item(logic [7:0] data_byte, logic has_byte, logic final_item,
                           bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data_byte;
    in_tuser  <= has_byte;
    in_tlast  <= final_item;
    do @(posedge clk); while (!in_tready);
    sb.note_item(data_byte, has_byte, final_item);
    items_sent++;
  endtask

  // Send a whole message of random bytes; stray empty items mixed in as noise.
  task automatic send_message(int len, bit fast);
    for (int i = 0; i < len; i++) begin
      bit fin;
      fin = (i == len - 1) && ($urandom_range(0, 1) == 1);
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0, fast);
      send_item(8'($urandom), 1'b1, fin, fast);
      if (fin) return;
    end
    send_item(8'($urandom), 1'b0, 1'b1, fast);
  endtask

  // Receiver: random stalls, plus one long hold-off when asked.
  initial begin
    int gap;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_sink = 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        gap = gap_len();
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
    end
  end

  // Check every accepted digest word and count cycles without progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_word(out_tdata, out_tlast);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("tb_sha1_message_digest_top failed");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    idle_cycles = 0;
    items_sent = 0;
    hold_sink = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    in_tlast  = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty message, "abc", extremes, byte on final item, empty final item.
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hA5, 1'b1, 1'b1);
    send_item(8'h5A, 1'b0, 1'b1);

    // Hold the receiver off while several messages queue up behind it.
    hold_sink = 1'b1;
    for (int m = 0; m < 3; m++) send_message($urandom_range(1, 4), 1);

    // Lengths that straddle the padding and block boundaries.
    send_message(55, 0);
    send_message(56, 0);
    send_message(64, 1);

    // Random messages: mostly short, a few spanning blocks.
    while (items_sent < 420) begin
      int len;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 12);
      send_message(len, 0);
    end
    in_tvalid <= 1'b0;

    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("tb_sha1_message_digest_top passed");
    end else begin
      $display("tb_sha1_message_digest_top failed");
    end
    $finish;
  end

endmodule
